// ----- rtl/core/dsha_pkg.sv -----
// Shared types, command and status structs, and constants of the double SHA-256 hasher.
// Used by dsha_ctrl, dsha_dp and double_sha256_hasher; depends on nothing else.
package dsha_pkg;

    localparam logic [1:0] MODE_DOUBLE = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_MID    = 2'd2;

    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] LEN_256    = 32'h0000_0100;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD,
        S_ZFILL,
        S_CINIT,
        S_ROUND,
        S_CFIN,
        S_SECOND,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        JOB_BLOCK,
        JOB_PAD,
        JOB_LAST,
        JOB_SECOND,
        JOB_MID
    } job_t;

    typedef enum logic [2:0] {
        WS_INPUT,
        WS_KEEP,
        WS_KEEP_PAD,
        WS_ZERO,
        WS_PAD80,
        WS_LEN_HI,
        WS_LEN_LO
    } wsel_t;

    typedef struct packed {
        logic       add_bytes;
        logic       win_write;
        wsel_t      wsel;
        logic       load_second;
        logic       comp_init;
        logic       comp_round;
        logic       comp_finish;
        logic       base_iv;
        logic       write_chain;
        logic       end_run;
        logic [2:0] emit_idx;
    } cmd_t;

    typedef struct packed {
        logic wib_is14;
        logic wib_is15;
        logic wib_full;
        logic round_last;
        logic vfull;
    } status_t;

endpackage

// ----- rtl/core/dsha_dp.sv -----
// Datapath of the double SHA-256 hasher: block window, chaining state, round logic, results.
// Depends on dsha_pkg; driven by the command struct from dsha_ctrl.
module dsha_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  dsha_pkg::cmd_t    cmd,
    input  logic [31:0]       message_word,
    input  logic [2:0]        valid_bytes,
    input  logic              final_word,
    output dsha_pkg::status_t status,
    output logic [31:0]       digest_word
);

    logic [31:0] win_reg [16];
    logic [31:0] chain_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] out_reg [8];
    logic [4:0]  wib_reg;
    logic [5:0]  round_reg;
    logic [31:0] bytes_reg;

    logic [2:0]  v_eff;
    logic [31:0] keep_mask;
    logic [31:0] pad_bits;
    logic [31:0] wdata;
    logic [32:0] bytes_sum;
    logic [31:0] base [8];
    logic [31:0] var_next [8];
    logic [31:0] w_new;
    logic [31:0] big0, big1, chs, maj, s0, s1, t1;

    function automatic logic [31:0] ror(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    // Valid byte count: the whole word unless this is the final word.
    always_comb
    begin
        if (!final_word || valid_bytes >= 3'd4)
            v_eff = 3'd4;
        else
            v_eff = valid_bytes;
        case (v_eff)
            3'd0:    begin keep_mask = 32'h0000_0000; pad_bits = 32'h8000_0000; end
            3'd1:    begin keep_mask = 32'hff00_0000; pad_bits = 32'h0080_0000; end
            3'd2:    begin keep_mask = 32'hffff_0000; pad_bits = 32'h0000_8000; end
            3'd3:    begin keep_mask = 32'hffff_ff00; pad_bits = 32'h0000_0080; end
            default: begin keep_mask = 32'hffff_ffff; pad_bits = 32'h0000_0000; end
        endcase
    end

    always_comb
    begin
        case (cmd.wsel)
            dsha_pkg::WS_INPUT:    wdata = message_word;
            dsha_pkg::WS_KEEP:     wdata = message_word & keep_mask;
            dsha_pkg::WS_KEEP_PAD: wdata = (message_word & keep_mask) | pad_bits;
            dsha_pkg::WS_PAD80:    wdata = dsha_pkg::PAD_WORD;
            dsha_pkg::WS_LEN_HI:   wdata = {29'd0, bytes_reg[31:29]};
            dsha_pkg::WS_LEN_LO:   wdata = {bytes_reg[28:0], 3'd0};
            default:               wdata = 32'd0;
        endcase
    end

    assign bytes_sum = {1'b0, bytes_reg} + {30'd0, v_eff};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            base[i] = cmd.base_iv ? dsha_pkg::IV[i] : chain_reg[i];
    end

    // One compression round and one step of the rolling message schedule.
    always_comb
    begin
        big1 = ror(var_reg[4], 6) ^ ror(var_reg[4], 11) ^ ror(var_reg[4], 25);
        chs  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1   = var_reg[7] + big1 + chs + dsha_pkg::ROUND_K[round_reg] + win_reg[0];
        big0 = ror(var_reg[0], 2) ^ ror(var_reg[0], 13) ^ ror(var_reg[0], 22);
        maj  = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
             ^ (var_reg[1] & var_reg[2]);
        var_next[0] = t1 + big0 + maj;
        var_next[1] = var_reg[0];
        var_next[2] = var_reg[1];
        var_next[3] = var_reg[2];
        var_next[4] = var_reg[3] + t1;
        var_next[5] = var_reg[4];
        var_next[6] = var_reg[5];
        var_next[7] = var_reg[6];
        s0 = ror(win_reg[1], 7) ^ ror(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = ror(win_reg[14], 17) ^ ror(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_second)
        begin
            for (int i = 0; i < 8; i++)
                win_reg[i] <= chain_reg[i];
            win_reg[8] <= dsha_pkg::PAD_WORD;
            for (int i = 9; i < 15; i++)
                win_reg[i] <= 32'd0;
            win_reg[15] <= dsha_pkg::LEN_256;
        end
        else if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= w_new;
        end
        else if (cmd.win_write)
        begin
            win_reg[wib_reg[3:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.comp_init)
        begin
            for (int i = 0; i < 8; i++)
                var_reg[i] <= base[i];
        end
        else if (cmd.comp_round)
        begin
            for (int i = 0; i < 8; i++)
                var_reg[i] <= var_next[i];
        end
        if (cmd.comp_finish)
        begin
            for (int i = 0; i < 8; i++)
                out_reg[i] <= base[i] + var_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= dsha_pkg::IV[i];
            wib_reg   <= 5'd0;
            round_reg <= 6'd0;
            bytes_reg <= 32'd0;
        end
        else
        begin
            if (cmd.end_run)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= dsha_pkg::IV[i];
            end
            else if (cmd.comp_finish && cmd.write_chain)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
            end

            if (cmd.end_run || cmd.comp_init)
                wib_reg <= 5'd0;
            else if (cmd.win_write)
                wib_reg <= wib_reg + 5'd1;

            if (cmd.comp_init)
                round_reg <= 6'd0;
            else if (cmd.comp_round)
                round_reg <= round_reg + 6'd1;

            if (cmd.end_run)
                bytes_reg <= 32'd0;
            else if (cmd.add_bytes)
                bytes_reg <= bytes_sum[32] ? 32'hffff_ffff : bytes_sum[31:0];
        end
    end

    assign status.wib_is14   = (wib_reg == 5'd14);
    assign status.wib_is15   = (wib_reg == 5'd15);
    assign status.wib_full   = (wib_reg == 5'd16);
    assign status.round_last = (round_reg == 6'd63);
    assign status.vfull      = (v_eff == 3'd4);
    assign digest_word       = out_reg[cmd.emit_idx];

endmodule

// ----- rtl/core/dsha_ctrl.sv -----
// Controller of the double SHA-256 hasher: mode register, sequencing of padding,
// compressions and result delivery. Depends on dsha_pkg.
module dsha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              final_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        word_index,
    output logic              last_result,
    input  dsha_pkg::status_t status,
    output dsha_pkg::cmd_t    cmd
);

    dsha_pkg::state_t state_reg, state_next;
    dsha_pkg::job_t   job_reg, job_next;
    logic [1:0] mode_reg;
    logic       fin_reg, fin_next;
    logic       pend_reg, pend_next;
    logic       lenph_reg, lenph_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       accept;
    logic       is_mid, is_single;

    assign accept    = in_valid && in_ready;
    assign is_mid    = (mode_reg == dsha_pkg::MODE_MID);
    assign is_single = (mode_reg == dsha_pkg::MODE_SINGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsha_pkg::S_IDLE;
            job_reg   <= dsha_pkg::JOB_BLOCK;
            mode_reg  <= dsha_pkg::MODE_DOUBLE;
            fin_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            lenph_reg <= 1'b0;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            fin_reg   <= fin_next;
            pend_reg  <= pend_next;
            lenph_reg <= lenph_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
                mode_reg <= cfg_wdata;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        fin_next   = fin_reg;
        pend_next  = pend_reg;
        lenph_next = lenph_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            dsha_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    fin_next = final_word;
                    if (is_mid)
                    begin
                        job_next = dsha_pkg::JOB_MID;
                        if (final_word || status.wib_is15)
                            state_next = status.wib_is15 ? dsha_pkg::S_CINIT
                                                         : dsha_pkg::S_ZFILL;
                    end
                    else if (!final_word)
                    begin
                        job_next = dsha_pkg::JOB_BLOCK;
                        if (status.wib_is15)
                            state_next = dsha_pkg::S_CINIT;
                    end
                    else
                    begin
                        job_next   = dsha_pkg::JOB_PAD;
                        pend_next  = status.vfull;
                        lenph_next = 1'b0;
                        state_next = status.wib_is15 ? dsha_pkg::S_CINIT : dsha_pkg::S_PAD;
                    end
                end
            end
            dsha_pkg::S_PAD:
            begin
                if (pend_reg)
                    pend_next = 1'b0;
                else if (!lenph_reg && status.wib_is14)
                    lenph_next = 1'b1;
                if (status.wib_is15)
                begin
                    state_next = dsha_pkg::S_CINIT;
                    job_next   = (lenph_reg && !pend_reg) ? dsha_pkg::JOB_LAST
                                                          : dsha_pkg::JOB_PAD;
                end
            end
            dsha_pkg::S_ZFILL:
            begin
                if (status.wib_full)
                    state_next = dsha_pkg::S_CINIT;
            end
            dsha_pkg::S_CINIT:
                state_next = dsha_pkg::S_ROUND;
            dsha_pkg::S_ROUND:
            begin
                if (status.round_last)
                    state_next = dsha_pkg::S_CFIN;
            end
            dsha_pkg::S_CFIN:
            begin
                cnt_next = 3'd0;
                case (job_reg)
                    dsha_pkg::JOB_BLOCK:  state_next = dsha_pkg::S_IDLE;
                    dsha_pkg::JOB_PAD:    state_next = dsha_pkg::S_PAD;
                    dsha_pkg::JOB_LAST:
                        state_next = is_single ? dsha_pkg::S_EMIT : dsha_pkg::S_SECOND;
                    default:              state_next = dsha_pkg::S_EMIT;
                endcase
            end
            dsha_pkg::S_SECOND:
            begin
                job_next   = dsha_pkg::JOB_SECOND;
                state_next = dsha_pkg::S_CINIT;
            end
            dsha_pkg::S_EMIT:
            begin
                if (out_ready)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                        state_next = dsha_pkg::S_IDLE;
                end
            end
            default:
                state_next = dsha_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd             = '0;
        cmd.wsel        = dsha_pkg::WS_ZERO;
        cmd.emit_idx    = cnt_reg;
        cmd.base_iv     = (job_reg == dsha_pkg::JOB_MID) || (job_reg == dsha_pkg::JOB_SECOND);
        cmd.write_chain = !cmd.base_iv;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        case (state_reg)
            dsha_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.add_bytes = accept;
                cmd.win_write = accept;
                if (is_mid)
                    cmd.wsel = final_word ? dsha_pkg::WS_KEEP : dsha_pkg::WS_INPUT;
                else if (final_word && !status.vfull)
                    cmd.wsel = dsha_pkg::WS_KEEP_PAD;
                else
                    cmd.wsel = dsha_pkg::WS_INPUT;
            end
            dsha_pkg::S_PAD:
            begin
                cmd.win_write = 1'b1;
                if (pend_reg)
                    cmd.wsel = dsha_pkg::WS_PAD80;
                else if (lenph_reg)
                    cmd.wsel = dsha_pkg::WS_LEN_LO;
                else if (status.wib_is14)
                    cmd.wsel = dsha_pkg::WS_LEN_HI;
                else
                    cmd.wsel = dsha_pkg::WS_ZERO;
            end
            dsha_pkg::S_ZFILL:
                cmd.win_write = !status.wib_full;
            dsha_pkg::S_CINIT:
                cmd.comp_init = 1'b1;
            dsha_pkg::S_ROUND:
                cmd.comp_round = 1'b1;
            dsha_pkg::S_CFIN:
            begin
                cmd.comp_finish = 1'b1;
                cmd.end_run     = (job_reg == dsha_pkg::JOB_SECOND)
                               || (job_reg == dsha_pkg::JOB_LAST && is_single)
                               || (job_reg == dsha_pkg::JOB_MID && fin_reg);
            end
            dsha_pkg::S_SECOND:
                cmd.load_second = 1'b1;
            dsha_pkg::S_EMIT:
                out_valid = 1'b1;
            default:
                cmd.wsel = dsha_pkg::WS_ZERO;
        endcase
    end

    assign word_index  = cnt_reg;
    assign last_result = (cnt_reg == 3'd7);

endmodule

// ----- rtl/core/double_sha256_hasher.sv -----
// Top level of the double SHA-256 hasher.
// Instantiates dsha_ctrl and dsha_dp; depends on dsha_pkg.

// The block takes a message as big-endian 32-bit items, one per accepted handshake,
// and returns eight state words as eight result items, word_index 0 to 7, with
// last_result high on the eighth. Each time a 64-byte block is complete, the one
// shared round unit runs a load, 64 rounds and a final add, and no word is taken
// until it is done. Outside midstate mode, on the final word the block writes one
// padding word per cycle, compresses the padded tail, and in double mode loads the
// digest as a new block and compresses once more; in midstate mode it fills the rest
// of the block with zeros and compresses it. The eight words are then delivered, each
// held until out_ready. One message item is worked on at a time: in_ready is high
// only while the block waits for a word. The mode register (0 double, 1 single,
// 2 midstate, 3 acts as double) is written through cfg_we and cfg_wdata and must be
// changed only while the block is idle.
module double_sha256_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] message_word,
    input  logic [2:0]  valid_bytes,
    input  logic        final_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_result
);

    dsha_pkg::cmd_t    cmd;
    dsha_pkg::status_t status;

    // Sequencing: accepts items, steps the padding and the compressions.
    dsha_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .final_word  (final_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_index  (word_index),
        .last_result (last_result),
        .status      (status),
        .cmd         (cmd)
    );

    // Storage and arithmetic: window, chaining state, round unit and result words.
    dsha_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .final_word   (final_word),
        .status       (status),
        .digest_word  (digest_word)
    );

endmodule
